[rtl/quadratic_root_solver_defines.svh]
// Assertion helpers included by quadratic_root_solver.sv; the asserting module supplies clk_i and rst_ni.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Same-cycle implication.
`define QRS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define QRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/qrs_pkg.sv]
package qrs_pkg;

  localparam int unsigned OUT_W      = 34;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CNT_W      = 2;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

endpackage

[rtl/qrs_sqrt_cell.sv]
module qrs_sqrt_cell #(
  parameter int unsigned SW    = 33,
  parameter int unsigned SIDEW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2*SW-1:0]    rad_i,
  input  logic [SW+1:0]      rem_i,
  input  logic [SW-1:0]      root_i,
  input  logic [SIDEW-1:0]   side_i,
  output logic               valid_o,
  output logic [2*SW-1:0]    rad_o,
  output logic [SW+1:0]      rem_o,
  output logic [SW-1:0]      root_o,
  output logic [SIDEW-1:0]   side_o
);

  logic [SW+1:0] rem_sh;
  logic [SW+1:0] trial;
  logic          ge;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_sh = {rem_i[SW-1:0], rad_i[2*SW-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i << 2;
      rem_o  <= ge ? (rem_sh - trial) : rem_sh;
      root_o <= {root_i[SW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

[rtl/qrs_div_cell.sv]
module qrs_div_cell #(
  parameter int unsigned NW    = 34,
  parameter int unsigned DENW  = 17,
  parameter int unsigned SIDEW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NW-1:0]    pnum_i,
  input  logic [NW-1:0]    mnum_i,
  input  logic [DENW-1:0]  prem_i,
  input  logic [DENW-1:0]  mrem_i,
  input  logic [DENW-1:0]  den_i,
  input  logic [SIDEW-1:0] side_i,
  output logic             valid_o,
  output logic [NW-1:0]    pnum_o,
  output logic [NW-1:0]    mnum_o,
  output logic [DENW-1:0]  prem_o,
  output logic [DENW-1:0]  mrem_o,
  output logic [DENW-1:0]  den_o,
  output logic [SIDEW-1:0] side_o
);

  logic [DENW:0] psh, msh, den_x, pdif, mdif;
  logic          pge, mge;

  // One quotient bit per lane; quotient bits fill the dividend from below.
  assign den_x = {1'b0, den_i};
  assign psh   = {prem_i, pnum_i[NW-1]};
  assign msh   = {mrem_i, mnum_i[NW-1]};
  assign pge   = (psh >= den_x);
  assign mge   = (msh >= den_x);
  assign pdif  = pge ? (psh - den_x) : psh;
  assign mdif  = mge ? (msh - den_x) : msh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnum_o <= {pnum_i[NW-2:0], pge};
      mnum_o <= {mnum_i[NW-2:0], mge};
      prem_o <= pdif[DENW-1:0];
      mrem_o <= mdif[DENW-1:0];
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

[rtl/quadratic_root_solver.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: coef_square, coef_linear, coef_const
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: root_plus, root_minus; tuser: root_count
//
// Takes one equation per cycle while s_axis_tready is high; every stage advances together.
// Registers in order: stage 1, stage 2, SW square-root cells, stage 3, NW divider cells,
// then the output buffer; the square-root chain and the two-lane divider chain set the depth.
// A two-entry output buffer lets the pipe keep running while a result waits;
// s_axis_tready drops only when both entries are full.
// Reset clears the valid bits and the buffer count only.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // coef_square, coef_linear, coef_const from bit 0 up, zero padded
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // root_plus, root_minus from bit 0 up, zero padded
  output logic [qrs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // root_count
  output logic [qrs_pkg::CNT_W-1:0]            m_axis_tuser
);
  import qrs_pkg::*;

  localparam int unsigned CW    = COEF_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned PW    = 2*CW;
  localparam int unsigned DSW   = 2*CW+1;
  localparam int unsigned VW    = DSW+2*F;
  localparam int unsigned SW    = (VW+1)/2;
  localparam int unsigned RW    = 2*SW;
  localparam int unsigned NBW   = CW+F+1;
  localparam int unsigned DENW  = CW+1;
  localparam int unsigned NW    = ((CW+F > SW) ? CW+F : SW)+1;
  localparam int unsigned NSW   = NW+1;
  localparam int unsigned SIDEW = CNT_W+NBW+DENW+1;
  localparam int unsigned DSIDW = CNT_W+2;
  localparam int unsigned QXW   = (NW+1 > OUT_W) ? NW+1 : OUT_W;

  logic en;

  // ---------------- stage 1: magnitudes and products ----------------
  logic [CW-1:0] a_raw, b_raw, c_raw, a_mag, b_mag, c_mag;
  assign a_raw = s_axis_tdata[CW-1:0];
  assign b_raw = s_axis_tdata[2*CW-1:CW];
  assign c_raw = s_axis_tdata[3*CW-1:2*CW];
  assign a_mag = a_raw[CW-1] ? (~a_raw + 1'b1) : a_raw;
  assign b_mag = b_raw[CW-1] ? (~b_raw + 1'b1) : b_raw;
  assign c_mag = c_raw[CW-1] ? (~c_raw + 1'b1) : c_raw;

  logic          s1_v_q;
  logic [PW-1:0] s1_sq_q, s1_pac_q;
  logic          s1_pneg_q, s1_azero_q, s1_aneg_q;
  logic [CW-1:0] s1_amag_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sq_q    <= PW'(b_mag) * PW'(b_mag);
      s1_pac_q   <= PW'(a_mag) * PW'(c_mag);
      s1_pneg_q  <= a_raw[CW-1] ^ c_raw[CW-1];
      s1_azero_q <= (a_raw == '0);
      s1_aneg_q  <= a_raw[CW-1];
      s1_amag_q  <= a_mag;
      s1_b_q     <= b_raw;
    end
  end

  // ---------------- stage 2: discriminant and root count ----------------
  logic [DSW-1:0]        sq_x, p4, disc;
  logic                  lt;
  logic [CNT_W-1:0]      cnt2;
  logic signed [NBW-1:0] b_ext, nb2;

  assign sq_x  = DSW'(s1_sq_q);
  assign p4    = DSW'({s1_pac_q, 2'b00});
  assign lt    = (sq_x < p4);
  assign disc  = s1_pneg_q ? (sq_x + p4) : (sq_x - p4);
  assign b_ext = NBW'($signed(s1_b_q));
  assign nb2   = -(b_ext <<< F);

  always_comb begin
    priority if (s1_azero_q || (!s1_pneg_q && lt)) begin
      cnt2 = CNT_NONE;
    end else if (disc == '0) begin
      cnt2 = CNT_ONE;
    end else begin
      cnt2 = CNT_TWO;
    end
  end

  logic             s2_v_q;
  logic [RW-1:0]    s2_rad_q;
  logic [SIDEW-1:0] s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rad_q  <= RW'(disc) << (2*F);
      s2_side_q <= {cnt2, nb2, {s1_amag_q, 1'b0}, s1_aneg_q};
    end
  end

  // ---------------- square-root chain: one root bit per cell ----------------
  logic             sq_v    [SW+1];
  logic [RW-1:0]    sq_rad  [SW+1];
  logic [SW+1:0]    sq_rem  [SW+1];
  logic [SW-1:0]    sq_root [SW+1];
  logic [SIDEW-1:0] sq_side [SW+1];

  assign sq_v[0]    = s2_v_q;
  assign sq_rad[0]  = s2_rad_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s2_side_q;

  for (genvar gi = 0; gi < SW; gi++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .SIDEW(SIDEW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[gi]),
      .rad_i   (sq_rad[gi]),
      .rem_i   (sq_rem[gi]),
      .root_i  (sq_root[gi]),
      .side_i  (sq_side[gi]),
      .valid_o (sq_v[gi+1]),
      .rad_o   (sq_rad[gi+1]),
      .rem_o   (sq_rem[gi+1]),
      .root_o  (sq_root[gi+1]),
      .side_o  (sq_side[gi+1])
    );
  end

  // ---------------- stage 3: numerators, signs, magnitudes ----------------
  logic [CNT_W-1:0]      cnt3;
  logic signed [NBW-1:0] nb3;
  logic [DENW-1:0]       den3;
  logic                  aneg3;
  logic signed [NSW-1:0] nb_x, s_x, nump, numm;
  logic [NSW-1:0]        pabs, mabs;

  assign {cnt3, nb3, den3, aneg3} = sq_side[SW];
  assign nb_x = NSW'(nb3);
  assign s_x  = NSW'($signed({1'b0, sq_root[SW]}));
  assign nump = nb_x + s_x;
  assign numm = nb_x - s_x;
  assign pabs = nump[NSW-1] ? NSW'(-nump) : NSW'(nump);
  assign mabs = numm[NSW-1] ? NSW'(-numm) : NSW'(numm);

  logic             s3_v_q;
  logic [NW-1:0]    s3_pnum_q, s3_mnum_q;
  logic [DENW-1:0]  s3_den_q;
  logic [DSIDW-1:0] s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= sq_v[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pnum_q <= pabs[NW-1:0];
      s3_mnum_q <= mabs[NW-1:0];
      s3_den_q  <= den3;
      s3_side_q <= {cnt3, nump[NSW-1] ^ aneg3, numm[NSW-1] ^ aneg3};
    end
  end

  // ---------------- divider chain: one quotient bit per cell, two lanes ----------------
  logic             dv_v    [NW+1];
  logic [NW-1:0]    dv_pnum [NW+1];
  logic [NW-1:0]    dv_mnum [NW+1];
  logic [DENW-1:0]  dv_prem [NW+1];
  logic [DENW-1:0]  dv_mrem [NW+1];
  logic [DENW-1:0]  dv_den  [NW+1];
  logic [DSIDW-1:0] dv_side [NW+1];

  assign dv_v[0]    = s3_v_q;
  assign dv_pnum[0] = s3_pnum_q;
  assign dv_mnum[0] = s3_mnum_q;
  assign dv_prem[0] = '0;
  assign dv_mrem[0] = '0;
  assign dv_den[0]  = s3_den_q;
  assign dv_side[0] = s3_side_q;

  for (genvar gj = 0; gj < NW; gj++) begin : g_div
    qrs_div_cell #(.NW(NW), .DENW(DENW), .SIDEW(DSIDW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[gj]),
      .pnum_i  (dv_pnum[gj]),
      .mnum_i  (dv_mnum[gj]),
      .prem_i  (dv_prem[gj]),
      .mrem_i  (dv_mrem[gj]),
      .den_i   (dv_den[gj]),
      .side_i  (dv_side[gj]),
      .valid_o (dv_v[gj+1]),
      .pnum_o  (dv_pnum[gj+1]),
      .mnum_o  (dv_mnum[gj+1]),
      .prem_o  (dv_prem[gj+1]),
      .mrem_o  (dv_mrem[gj+1]),
      .den_o   (dv_den[gj+1]),
      .side_o  (dv_side[gj+1])
    );
  end

  // ---------------- sign, masking ----------------
  logic [CNT_W-1:0] cntf;
  logic             pnegf, mnegf;
  logic [QXW-1:0]   qp_x, qm_x;
  logic [OUT_W-1:0] rplus, rminus;

  assign {cntf, pnegf, mnegf} = dv_side[NW];
  // Truncate toward zero: divide magnitudes, then restore the sign.
  assign qp_x   = pnegf ? (-QXW'(dv_pnum[NW])) : QXW'(dv_pnum[NW]);
  assign qm_x   = mnegf ? (-QXW'(dv_mnum[NW])) : QXW'(dv_mnum[NW]);
  // Zero the roots that the count does not cover.
  assign rplus  = (cntf == CNT_NONE) ? '0 : qp_x[OUT_W-1:0];
  assign rminus = (cntf == CNT_TWO) ? qm_x[OUT_W-1:0] : '0;

  // ---------------- two-entry output buffer ----------------
  localparam int unsigned ENT_W = CNT_W + 2*OUT_W;

  logic [1:0]       cnt_q;
  logic [ENT_W-1:0] head_q, tail_q;
  logic             push, pop;
  logic [ENT_W-1:0] new_ent;

  assign en       = (cnt_q != 2'd2);
  assign push     = en && dv_v[NW];
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign new_ent  = {cntf, rminus, rplus};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Hold the head until taken; refill it from the skid entry or the pipe.
  always_ff @(posedge clk_i) begin
    unique case (cnt_q)
      2'd0: begin
        if (push) head_q <= new_ent;
      end
      2'd1: begin
        if (push && pop) head_q <= new_ent;
        else if (push) tail_q <= new_ent;
      end
      default: begin
        if (pop) head_q <= tail_q;
      end
    endcase
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tuser  = head_q[ENT_W-1 -: CNT_W];
  assign m_axis_tdata  = OUT_DATA_W'(head_q[2*OUT_W-1:0]);

  `QRS_ASSERT_NOW(a_stall_has_out, !s_axis_tready, m_axis_tvalid, "stall without result")
  `QRS_ASSERT_NOW(a_minus_zero, m_axis_tvalid && (m_axis_tuser != CNT_TWO),
                  m_axis_tdata[2*OUT_W-1:OUT_W] == '0, "minus root not zeroed")
  `QRS_ASSERT_NOW(a_plus_zero, m_axis_tvalid && (m_axis_tuser == CNT_NONE),
                  m_axis_tdata[OUT_W-1:0] == '0, "plus root not zeroed")
  `QRS_ASSERT_NEXT(a_drain, pop && (cnt_q == 2'd1) && !push, !m_axis_tvalid,
                   "buffer did not drain")

endmodule
